// File: design/ple_pkg.sv
package ple_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// File: design/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/positional_list_engine.sv
// Positional list engine: an ordered list of up to DEPTH words held in one
// synchronous RAM and addressed by 1-based position.
//
// Input channel: drive start with in_opcode, in_position and in_value; the
// word is taken at the clock edge where start is high and busy is low.
// Result channel: out_valid pulses for one cycle with out_read_value,
// out_list_length, out_is_empty and out_status. The receiver cannot stall;
// every request yields exactly one result.
//
// Append, any error and delete of the tail element answer in the cycle
// after acceptance. A read passes through the RAM read register and
// state S_RD. An insert runs S_SHUP over the elements from the tail down
// to the position, then S_INSW writes the new word; a delete at p < n
// runs S_SHDN over the elements behind p.
// Insert and delete move the elements behind the position one RAM entry
// per cycle: read at one address, write the neighbor in the cycle after. That
// single write port sets the rate. busy stays high until the result shows.
// Reset empties the list at once (length zero); RAM contents are not
// cleared, since only written entries are ever read.
module positional_list_engine #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_list_length,
  output logic        out_is_empty,
  output logic [1:0]  out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = CW + 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHUP,
    S_INSW,
    S_SHDN,
    S_RD
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         lim_r, lim_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic                  ov_r, ov_nxt;
  logic [31:0]           ord_r, ord_nxt;
  logic [1:0]            ost_r, ost_nxt;
  logic [6:0]            olen_r, olen_nxt;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [ELEM_WIDTH-1:0] wdata, rdata;

  logic [ELEM_WIDTH+31:0] vext, rext;
  logic [ELEM_WIDTH-1:0]  vin;
  logic [31:0]            rd32;
  logic [AW+6:0]          pext, pm1;
  logic [AW-1:0]          pos_a, posm1_a, cntm1_a, cnt_a;
  logic [MW-1:0]          posx, cntx;
  logic [CW+6:0]          cnt_ext;
  logic                   accept, pos_ok, full;

  ple_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Width fitting: truncate or zero-extend between bus and element width.
  assign vext    = {{ELEM_WIDTH{1'b0}}, in_value};
  assign vin     = vext[ELEM_WIDTH-1:0];
  assign rext    = {32'd0, rdata};
  assign rd32    = rext[31:0];
  assign pext    = {{AW{1'b0}}, in_position};
  assign pm1     = pext - (AW + 7)'(1);
  assign pos_a   = pext[AW-1:0];
  assign posm1_a = pm1[AW-1:0];
  assign cnt_a   = cnt_r[AW-1:0];
  assign cntm1_a = AW'(cnt_r - CW'(1));
  assign posx    = {{CW{1'b0}}, in_position};
  assign cntx    = {7'd0, cnt_r};

  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(DEPTH));
  assign pos_ok = (in_position != 7'd0) && (posx <= cntx) && (posx <= MW'(DEPTH));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    val_nxt   = val_r;
    ov_nxt    = 1'b0;
    ord_nxt   = 32'd0;
    ost_nxt   = ple_pkg::ST_OK;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = rdata;
    raddr     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (ple_pkg::op_t'(in_opcode))
            ple_pkg::OP_APPEND: begin
              ov_nxt = 1'b1;
              if (full) begin
                ost_nxt = ple_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_a;
                wdata   = vin;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            ple_pkg::OP_INSERT: begin
              if (full) begin
                ov_nxt  = 1'b1;
                ost_nxt = ple_pkg::ST_FULL;
              end else if (!pos_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = ple_pkg::ST_RANGE;
              end else begin
                // walk from the tail down, opening a hole at the position
                raddr     = cntm1_a;
                idx_nxt   = cntm1_a;
                lim_nxt   = posm1_a;
                val_nxt   = vin;
                state_nxt = S_SHUP;
              end
            end
            ple_pkg::OP_DELETE: begin
              if (!pos_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = ple_pkg::ST_RANGE;
              end else if (posx == cntx) begin
                ov_nxt  = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                // walk from the position up, closing the gap
                raddr     = pos_a;
                idx_nxt   = pos_a;
                lim_nxt   = cntm1_a;
                state_nxt = S_SHDN;
              end
            end
            ple_pkg::OP_READ: begin
              if (!pos_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = ple_pkg::ST_RANGE;
              end else begin
                raddr     = posm1_a;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHUP: begin
        we    = 1'b1;
        waddr = idx_r + AW'(1);
        if (idx_r == lim_r) begin
          state_nxt = S_INSW;
        end else begin
          raddr   = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_INSW: begin
        we        = 1'b1;
        waddr     = lim_r;
        wdata     = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHDN: begin
        we    = 1'b1;
        waddr = idx_r - AW'(1);
        if (idx_r == lim_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr   = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_RD: begin
        ord_nxt   = rd32;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // list length as seen on the port: count masked to 7 bits
  assign cnt_ext  = {7'd0, cnt_nxt};
  assign olen_nxt = cnt_ext[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    val_r <= val_nxt;
    if (ov_nxt) begin
      ord_r  <= ord_nxt;
      ost_r  <= ost_nxt;
      olen_r <= olen_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_read_value  = ord_r;
  assign out_status      = ost_r;
  assign out_list_length = olen_r;
  assign out_is_empty    = (olen_r == 7'd0) && (cnt_r == '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("list count above depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted word neither answered nor in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ple_pkg::ST_FULL) |-> (cnt_r == CW'(DEPTH)))
    else $error("full status with room left");

  a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (waddr < AW'(DEPTH - 1) || waddr == AW'(DEPTH - 1)))
    else $error("write beyond list depth");

endmodule

// File: verif/positional_list_engine_tb.sv
`timescale 1ns / 100ps

module positional_list_engine_tb;

  localparam int LIST_DEPTH  = 64;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    ple_pkg::op_t opcode;
    logic [6:0]   position;
    logic [31:0]  value;
  } request_t;

  typedef struct packed {
    logic [31:0]      read_value;
    logic [6:0]       list_length;
    logic             is_empty;
    ple_pkg::status_t status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [31:0] out_read_value;
  logic [6:0]  out_list_length;
  logic        out_is_empty;
  logic [1:0]  out_status;

  positional_list_engine dut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_position, .in_value,
    .out_valid, .out_read_value, .out_list_length, .out_is_empty, .out_status
  );

  always #10 clk = ~clk;

  // Shadow copy of the list, updated as each word is accepted.
  logic [31:0] shadow_list [LIST_DEPTH];
  int          shadow_len = 0;

  request_t pending_words [$];
  reply_t   expected_replies [$];

  int  mismatch_count = 0;
  int  idle_left      = 0;
  bit  calm_phase     = 1'b0;  // last part of the run: no sender gaps
  bit  hold_sender    = 1'b0;  // pause the sender until replies drain
  bit  feeding_done   = 1'b0;
  int  quiet_cycles   = 0;

  // Apply one request to the shadow list and return the reply it yields.
  function automatic reply_t apply_request(request_t rq);
    reply_t r;
    int     p;
    bit     pos_ok;
    r = '0;
    r.status = ple_pkg::ST_OK;
    p = rq.position;
    pos_ok = (p >= 1) && (p <= shadow_len);
    case (rq.opcode)
      ple_pkg::OP_APPEND: begin
        if (shadow_len >= LIST_DEPTH) r.status = ple_pkg::ST_FULL;
        else begin
          shadow_list[shadow_len] = rq.value;
          shadow_len++;
        end
      end
      ple_pkg::OP_INSERT: begin
        if (shadow_len >= LIST_DEPTH) r.status = ple_pkg::ST_FULL;
        else if (!pos_ok) r.status = ple_pkg::ST_RANGE;
        else begin
          for (int i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = rq.value;
          shadow_len++;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (!pos_ok) r.status = ple_pkg::ST_RANGE;
        else begin
          for (int i = p - 1; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (!pos_ok) r.status = ple_pkg::ST_RANGE;
        else r.read_value = shadow_list[p-1];
      end
    endcase
    r.list_length = shadow_len[6:0];
    r.is_empty    = (shadow_len == 0);
    return r;
  endfunction

  function automatic request_t make_word(ple_pkg::op_t op, int pos, logic [31:0] val);
    request_t rq;
    rq.opcode   = op;
    rq.position = pos[6:0];
    rq.value    = val;
    return rq;
  endfunction

  // Driver: present the head of the queue; drop it once accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_replies.push_back(apply_request(pending_words.pop_front()));
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (hold_sender && expected_replies.size() > 0) begin
        start <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > (start && !busy ? 0 : 0) &&
                   !(start && !busy && pending_words.size() == 0)) begin
        if (!calm_phase && $urandom_range(0, 9) == 0) begin
          idle_left <= $urandom_range(1, 12) - 1;
          start <= 1'b0;
        end else begin
          start       <= 1'b1;
          in_opcode   <= pending_words[0].opcode;
          in_position <= pending_words[0].position;
          in_value    <= pending_words[0].value;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed reply with the oldest expectation.
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n) begin
      quiet_cycles <= (out_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (out_valid) begin
        got = {out_read_value, out_list_length, out_is_empty,
               ple_pkg::status_t'(out_status)};
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected reply %h", got);
        end else begin
          want = expected_replies.pop_front();
          if (got.read_value !== want.read_value ||
              got.list_length !== want.list_length ||
              got.is_empty !== want.is_empty || got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp rd=%h len=%0d emp=%b st=%0d ",
                        "got rd=%h len=%0d emp=%b st=%0d"},
                       want.read_value, want.list_length, want.is_empty, want.status,
                       got.read_value, got.list_length, got.is_empty, got.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && quiet_cycles >= WATCH_LIMIT) begin
      $display("positional_list_engine_tb: done, errors");
      $finish;
    end
  end

  // Keep a rough length estimate so random traffic stays useful.
  function automatic int pick_position(int est_len);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(est_len + 1, 127);
    if (roll == 2) return est_len;
    if (est_len == 0) return $urandom_range(0, 2);
    return $urandom_range(1, est_len);
  endfunction

  initial begin
    int est_len;
    int roll;
    ple_pkg::op_t op;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list errors, value extremes, fill to full, edge positions.
    pending_words.push_back(make_word(ple_pkg::OP_READ, 1, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 1, 32'h1234));
    pending_words.push_back(make_word(ple_pkg::OP_DELETE, 1, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_APPEND, 127, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(ple_pkg::OP_APPEND, 0, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 1, 32'hA5A5_5A5A));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 3, 32'h5A5A_A5A5));
    pending_words.push_back(make_word(ple_pkg::OP_READ, 0, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_READ, 3, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_READ, 4, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_DELETE, 3, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_DELETE, 1, 32'h0));
    for (int i = 0; i < 64; i++)
      pending_words.push_back(make_word(ple_pkg::OP_APPEND, 0, $urandom()));
    pending_words.push_back(make_word(ple_pkg::OP_APPEND, 0, 32'h1));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 1, 32'h2));
    pending_words.push_back(make_word(ple_pkg::OP_READ, 64, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_READ, 65, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_DELETE, 64, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 63, 32'h3));
    pending_words.push_back(make_word(ple_pkg::OP_DELETE, 1, 32'h0));
    pending_words.push_back(make_word(ple_pkg::OP_INSERT, 127, 32'h4));
    est_len = 63;

    // Pause the sender until the directed part has fully drained.
    wait (pending_words.size() == 0 && !start);
    hold_sender = 1'b1;
    wait (expected_replies.size() == 0);
    hold_sender = 1'b0;

    // Random traffic, mostly valid positions, drifting the length up and down.
    for (int n = 0; n < 770; n++) begin
      roll = $urandom_range(0, 99);
      if (n == 700) begin
        wait (pending_words.size() == 0);
        calm_phase = 1'b1;
      end
      if (roll < (est_len < 32 ? 40 : 20)) op = ple_pkg::OP_APPEND;
      else if (roll < 50) op = ple_pkg::OP_INSERT;
      else if (roll < 75) op = ple_pkg::OP_DELETE;
      else op = ple_pkg::OP_READ;
      pending_words.push_back(make_word(op, pick_position(est_len), $urandom()));
      // Track only a coarse estimate; exact length lives in the shadow list.
      if (op == ple_pkg::OP_APPEND && est_len < LIST_DEPTH) est_len++;
      else if (op == ple_pkg::OP_INSERT && est_len > 0 && est_len < LIST_DEPTH) est_len++;
      else if (op == ple_pkg::OP_DELETE && est_len > 0) est_len--;
      if (pending_words.size() > 40) wait (pending_words.size() < 10);
    end

    wait (pending_words.size() == 0 && !start);
    wait (expected_replies.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("positional_list_engine_tb: done, clean");
    else
      $display("positional_list_engine_tb: done, errors");
    $finish;
  end

endmodule
